/* rtl/tss_pkg.sv */
// Shared constants and types for the Taylor-series sine pipeline.
// No dependencies.
package tss_pkg;

    localparam logic [31:0] PI_Q29     = 32'd1686629713;
    localparam logic [31:0] DEG180_Q22 = 32'd754974720;

    localparam int ANG_W  = 32;
    localparam int MAG_W  = 31;
    localparam int ACC_W  = 64;
    localparam int PROD_W = 62;

    typedef struct packed {
        logic neg;
        logic clamped;
    } tss_flags_t;

endpackage

/* rtl/taylor_series_sine.sv */
// Taylor-series sine, fully pipelined, one word per cycle unless stalled.
// Uses tss_pkg, tss_cdiv and tss_term.
//
// Usage:
//   Input channel angle_valid/angle_stall carries a signed angle, Q2.29
//   radians or Q9.22 degrees as set by angle_unit. Output channel
//   sine_valid/sine_stall returns the sine in Q1.30 and a flag that the
//   angle was saturated to +-pi or +-180 degrees.
//   angle_unit is written through angle_unit_we/angle_unit_wdata; the user
//   must do so only while the pipeline is empty; the block does not check.
//   The pipeline is made of the front end with the degree conversion
//   divider, six stages per series term (two for the 64x64 product, three
//   for the reciprocal divider, one for the sum), and the output rounding
//   register. Throughput is one word per cycle unless the output stalls;
//   every term has its own multipliers.
//   Reset clears all valid bits and sets angle_unit to radians.
//   While the output word is stalled the whole pipeline holds and
//   angle_stall is raised; nothing is dropped or repeated.
module taylor_series_sine import tss_pkg::*; #(
    parameter int TERMS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              angle_unit_we,
    input  logic              angle_unit_wdata,
    input  logic              angle_valid,
    output logic              angle_stall,
    input  logic [ANG_W-1:0]  angle,
    output logic              sine_valid,
    input  logic              sine_stall,
    output logic [ANG_W-1:0]  sine,
    output logic              clamped
);

    localparam int SIDE0 = MAG_W + 1 + $bits(tss_flags_t);

    logic               en;
    logic               unit_reg;
    logic [ANG_W-1:0]   mag_full;
    logic [ANG_W-1:0]   limit;
    logic               over;
    logic               v1_reg;
    logic [MAG_W-1:0]   mag1_reg;
    logic               unit1_reg;
    tss_flags_t         f1_reg;
    logic               v2_reg;
    logic [PROD_W-1:0]  prod2_reg;
    logic [SIDE0-1:0]   side2_reg;
    logic               dv_valid;
    logic [PROD_W-1:0]  dv_quot;
    logic [SIDE0-1:0]   dv_side;
    logic [MAG_W-1:0]   u_next;
    logic               v4_reg;
    logic [ACC_W-1:0]   term4_reg;
    logic [ACC_W-1:0]   x24_reg;
    tss_flags_t         f4_reg;

    logic               chain_valid [TERMS];
    logic [ACC_W-1:0]   chain_term  [TERMS];
    logic [ACC_W-1:0]   chain_x2    [TERMS];
    logic [ACC_W-1:0]   chain_sum   [TERMS];
    tss_flags_t         chain_flags [TERMS];

    logic [ACC_W-1:0]   fsum;
    logic               sneg;
    logic [ACC_W-1:0]   smag;
    logic [36:0]        rnd;
    logic [ANG_W-1:0]   rsat;
    logic [ANG_W-1:0]   sine_next;
    logic               vo_reg;
    logic [ANG_W-1:0]   sine_reg;
    logic               clamped_reg;

    assign en          = !(vo_reg && sine_stall);
    assign angle_stall = !en;

    // front end: magnitude and saturation
    assign mag_full = angle[ANG_W-1] ? (~angle + ANG_W'(1)) : angle;
    assign limit    = unit_reg ? DEG180_Q22 : PI_Q29;
    assign over     = mag_full > limit;

    assign u_next = dv_side[SIDE0-1] ? dv_quot[MAG_W-1:0] : dv_side[SIDE0-2 -: MAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= 1'b0;
        end
        else if (angle_unit_we)
        begin
            unit_reg <= angle_unit_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= angle_valid;
            v2_reg <= v1_reg;
            v4_reg <= dv_valid;
            vo_reg <= chain_valid[TERMS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag1_reg       <= over ? limit[MAG_W-1:0] : mag_full[MAG_W-1:0];
            unit1_reg      <= unit_reg;
            f1_reg.neg     <= angle[ANG_W-1];
            f1_reg.clamped <= over;
            prod2_reg      <= mag1_reg * PI_Q29[MAG_W-1:0];
            side2_reg      <= {unit1_reg, mag1_reg, f1_reg};
            term4_reg      <= ACC_W'(u_next) << 29;
            x24_reg        <= ACC_W'(u_next) * ACC_W'(u_next);
            f4_reg         <= dv_side[$bits(tss_flags_t)-1:0];
            sine_reg       <= sine_next;
            clamped_reg    <= chain_flags[TERMS-1].clamped;
        end
    end

    tss_cdiv #(
        .W  (PROD_W),
        .D  (int'(DEG180_Q22)),
        .SW (SIDE0)
    ) u_deg (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v2_reg),
        .dividend (prod2_reg),
        .side_in  (side2_reg),
        .out_valid(dv_valid),
        .quot     (dv_quot),
        .side_out (dv_side)
    );

    assign chain_valid[0] = v4_reg;
    assign chain_term[0]  = term4_reg;
    assign chain_x2[0]    = x24_reg;
    assign chain_sum[0]   = term4_reg;
    assign chain_flags[0] = f4_reg;

    for (genvar g = 1; g < TERMS; g++)
    begin : g_term
        tss_term #(
            .I (g)
        ) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (chain_valid[g-1]),
            .term_in  (chain_term[g-1]),
            .x2_in    (chain_x2[g-1]),
            .sum_in   (chain_sum[g-1]),
            .flags_in (chain_flags[g-1]),
            .out_valid(chain_valid[g]),
            .term_out (chain_term[g]),
            .x2_out   (chain_x2[g]),
            .sum_out  (chain_sum[g]),
            .flags_out(chain_flags[g])
        );
    end

    // round Q58 to Q1.30 by magnitude, saturate, apply sign
    assign fsum = chain_sum[TERMS-1];
    assign sneg = fsum[ACC_W-1];
    assign smag = sneg ? (~fsum + ACC_W'(1)) : fsum;
    assign rnd  = 37'(smag[63:28]) + 37'(smag[27]);
    assign rsat = (rnd > (37'(1) << 30)) ? (ANG_W'(1) << 30) : rnd[ANG_W-1:0];
    assign sine_next = (sneg ^ chain_flags[TERMS-1].neg) ? (~rsat + ANG_W'(1)) : rsat;

    assign sine_valid = vo_reg;
    assign sine       = sine_reg;
    assign clamped    = clamped_reg;

endmodule

/* rtl/tss_cdiv.sv */
// Pipelined rounded division by a constant: floor((dividend + D/2) / D).
// Reciprocal multiply in four partial products, then one correction step.
// No package dependencies; three register stages.
module tss_cdiv #(
    parameter int W  = 64,
    parameter int D  = 6,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  dividend,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [W-1:0]  quot,
    output logic [SW-1:0] side_out
);

    localparam int XW   = W + 1;
    localparam int L    = $clog2(D);
    localparam int S    = XW + L;
    localparam int MW   = XW + 1;
    localparam int H    = (XW + 1) / 2;
    localparam int FW   = XW + MW;
    localparam int HALF = D / 2;
    localparam logic [S:0]    POW   = {1'b1, {S{1'b0}}};
    localparam logic [S:0]    MFULL = POW / (S+1)'(D);
    localparam logic [MW-1:0] MAGIC = MFULL[MW-1:0];
    localparam logic [H-1:0]     M_LO = MAGIC[H-1:0];
    localparam logic [MW-H-1:0]  M_HI = MAGIC[MW-1:H];

    logic [XW-1:0]          x_next;
    logic [XW-1:0]          xa_reg;
    logic [XW-1:0]          xb_reg;
    logic [2*H-1:0]         pll_reg;
    logic [MW-1:0]          plh_reg;
    logic [XW-1:0]          phl_reg;
    logic [XW-H+MW-H-1:0]   phh_reg;
    logic [FW-1:0]          full;
    logic [XW-1:0]          qe_reg;
    logic [XW-1:0]          qd;
    logic [XW-1:0]          rem;
    logic [XW-1:0]          q_next;
    logic [W-1:0]           quot_reg;
    logic                   va_reg;
    logic                   vb_reg;
    logic                   vc_reg;
    logic [SW-1:0]          sa_reg;
    logic [SW-1:0]          sb_reg;
    logic [SW-1:0]          sc_reg;

    assign x_next = XW'(dividend) + XW'(HALF);

    assign full = (FW'(phh_reg) << (2*H)) + (FW'(plh_reg) << H)
                + (FW'(phl_reg) << H) + FW'(pll_reg);

    assign qd     = qe_reg * XW'(D);
    assign rem    = xb_reg - qd;
    assign q_next = (rem >= XW'(D)) ? qe_reg + XW'(1) : qe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg   <= x_next;
            pll_reg  <= x_next[H-1:0] * M_LO;
            plh_reg  <= MW'(x_next[H-1:0] * M_HI);
            phl_reg  <= XW'(x_next[XW-1:H] * M_LO);
            phh_reg  <= x_next[XW-1:H] * M_HI;
            sa_reg   <= side_in;
            xb_reg   <= xa_reg;
            qe_reg   <= XW'(full >> S);
            sb_reg   <= sa_reg;
            quot_reg <= q_next[W-1:0];
            sc_reg   <= sb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign quot      = quot_reg;
    assign side_out  = sc_reg;

endmodule

/* rtl/tss_term.sv */
// One series term: next term = round(round(T * x^2 / 2^58) / (2I(2I+1))),
// then added into the running sum with alternating sign.
// Uses tss_pkg and tss_cdiv; six register stages.
module tss_term import tss_pkg::*; #(
    parameter int I = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [ACC_W-1:0] term_in,
    input  logic [ACC_W-1:0] x2_in,
    input  logic [ACC_W-1:0] sum_in,
    input  tss_flags_t       flags_in,
    output logic             out_valid,
    output logic [ACC_W-1:0] term_out,
    output logic [ACC_W-1:0] x2_out,
    output logic [ACC_W-1:0] sum_out,
    output tss_flags_t       flags_out
);

    localparam int DIV  = (2 * I) * (2 * I + 1);
    localparam int SIDE = 2 * ACC_W + $bits(tss_flags_t);

    logic [63:0]        pll_reg;
    logic [63:0]        plh_reg;
    logic [63:0]        phl_reg;
    logic [63:0]        phh_reg;
    logic [ACC_W-1:0]   x2a_reg;
    logic [ACC_W-1:0]   suma_reg;
    tss_flags_t         fa_reg;
    logic               va_reg;
    logic [127:0]       prod;
    logic [ACC_W-1:0]   p_reg;
    logic [SIDE-1:0]    sideb_reg;
    logic               vb_reg;
    logic               dv_valid;
    logic [ACC_W-1:0]   dv_quot;
    logic [SIDE-1:0]    dv_side;
    logic [ACC_W-1:0]   dv_sum;
    logic [ACC_W-1:0]   sum_next;
    logic               vo_reg;
    logic [ACC_W-1:0]   term_reg;
    logic [ACC_W-1:0]   x2o_reg;
    logic [ACC_W-1:0]   sum_reg;
    tss_flags_t         fo_reg;

    assign prod = (128'(phh_reg) << 64) + (128'(plh_reg) << 32)
                + (128'(phl_reg) << 32) + 128'(pll_reg) + (128'(1) << 57);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vo_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg   <= term_in[31:0]  * x2_in[31:0];
            plh_reg   <= term_in[31:0]  * x2_in[63:32];
            phl_reg   <= term_in[63:32] * x2_in[31:0];
            phh_reg   <= term_in[63:32] * x2_in[63:32];
            x2a_reg   <= x2_in;
            suma_reg  <= sum_in;
            fa_reg    <= flags_in;
            p_reg     <= prod[121:58];
            sideb_reg <= {x2a_reg, suma_reg, fa_reg};
            term_reg  <= dv_quot;
            x2o_reg   <= dv_side[SIDE-1 -: ACC_W];
            sum_reg   <= sum_next;
            fo_reg    <= dv_side[$bits(tss_flags_t)-1:0];
        end
    end

    tss_cdiv #(
        .W  (ACC_W),
        .D  (DIV),
        .SW (SIDE)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (vb_reg),
        .dividend (p_reg),
        .side_in  (sideb_reg),
        .out_valid(dv_valid),
        .quot     (dv_quot),
        .side_out (dv_side)
    );

    assign dv_sum   = dv_side[$bits(tss_flags_t) +: ACC_W];
    assign sum_next = (I % 2 == 1) ? dv_sum - dv_quot : dv_sum + dv_quot;

    assign out_valid = vo_reg;
    assign term_out  = term_reg;
    assign x2_out    = x2o_reg;
    assign sum_out   = sum_reg;
    assign flags_out = fo_reg;

endmodule

/* dv/tb_taylor_series_sine.sv */
// Testbench for taylor_series_sine: random and directed angles in both units,
// checked against an in-bench fixed-point Taylor-series sine model.
// Depends on rtl/tss_pkg.sv and rtl/taylor_series_sine.sv.
`timescale 1ns / 100ps

module tb_taylor_series_sine import tss_pkg::*;;

    localparam int N_TERMS    = 32;
    localparam int LATENCY    = 7 + 6 * (N_TERMS - 1);
    localparam int IDLE_LIMIT = 20000;
    localparam logic UNIT_RAD = 1'b0;
    localparam logic UNIT_DEG = 1'b1;

    typedef struct {
        logic [31:0] sine;
        logic        clamped;
    } sine_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             angle_unit_we = 1'b0;
    logic             angle_unit_wdata = 1'b0;
    logic             angle_valid = 1'b0;
    logic             angle_stall;
    logic [ANG_W-1:0] angle = '0;
    logic             sine_valid;
    logic             sine_stall = 1'b0;
    logic [ANG_W-1:0] sine;
    logic             clamped;

    logic [31:0] pending_angles[$];
    sine_word_t  expected_sines[$];
    logic        unit_model = UNIT_RAD;
    int          errors = 0;
    int          idle_cycles = 0;
    int          send_gap = 0;
    int          recv_gap = 0;

    taylor_series_sine #(.TERMS(N_TERMS)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .angle_unit_we    (angle_unit_we),
        .angle_unit_wdata (angle_unit_wdata),
        .angle_valid      (angle_valid),
        .angle_stall      (angle_stall),
        .angle            (angle),
        .sine_valid       (sine_valid),
        .sine_stall       (sine_stall),
        .sine             (sine),
        .clamped          (clamped)
    );

    always #4 clk = ~clk;

    function automatic sine_word_t predict_sine(logic [31:0] raw, logic unit);
        sine_word_t   w;
        logic         neg;
        logic [63:0]  mag, lim, u, x2, term, sum, p, d, smag, r;
        logic [127:0] prod;
        logic         sneg;
        neg = raw[31];
        mag = {32'd0, neg ? (~raw + 32'd1) : raw};
        lim = unit ? {32'd0, DEG180_Q22} : {32'd0, PI_Q29};
        w.clamped = 1'b0;
        if (mag > lim)
        begin
            mag = lim;
            w.clamped = 1'b1;
        end
        u = mag;
        if (unit)
            u = (mag * {32'd0, PI_Q29} + {32'd0, DEG180_Q22} / 2) / {32'd0, DEG180_Q22};
        x2 = u * u;
        term = u << 29;
        sum = term;
        for (int i = 1; i < N_TERMS; i++)
        begin
            d = 64'(2 * i) * 64'(2 * i + 1);
            prod = {64'd0, term} * {64'd0, x2} + (128'd1 << 57);
            p = prod[121:58];
            term = p / d + (((p % d) >= (d - d / 2)) ? 64'd1 : 64'd0);
            if (i % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        sneg = sum[63];
        smag = sneg ? (~sum + 64'd1) : sum;
        r = (smag >> 28) + ((smag >> 27) & 64'd1);
        if (r > (64'd1 << 30))
            r = 64'd1 << 30;
        if (neg)
            sneg = ~sneg;
        w.sine = sneg ? (~r[31:0] + 32'd1) : r[31:0];
        return w;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int random_gap();
        int k;
        k = $urandom_range(0, 19);
        if (k < 13)
            return 0;
        else if (k < 18)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid <= 1'b0;
        end
        else if (!angle_valid || !angle_stall)
        begin
            if (angle_valid)
                expected_sines.push_back(predict_sine(angle, unit_model));
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                angle_valid <= 1'b0;
            end
            else if (pending_angles.size() > 0)
            begin
                angle <= pending_angles.pop_front();
                angle_valid <= 1'b1;
                send_gap <= random_gap();
            end
            else
            begin
                angle_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sine_valid && !sine_stall)
            begin
                sine_word_t exp_w;
                if (expected_sines.size() == 0)
                    report_mismatch("unexpected sine word");
                else
                begin
                    exp_w = expected_sines.pop_front();
                    if (sine !== exp_w.sine)
                        report_mismatch($sformatf("sine %h expected %h", sine, exp_w.sine));
                    if (clamped !== exp_w.clamped)
                        report_mismatch($sformatf("clamped %b expected %b",
                                                  clamped, exp_w.clamped));
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                sine_stall <= 1'b1;
            end
            else
            begin
                recv_gap <= random_gap();
                sine_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((angle_valid && !angle_stall) || (sine_valid && !sine_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_angles.size() != 0 || angle_valid || expected_sines.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    task automatic write_unit(logic v);
        @(posedge clk);
        angle_unit_we <= 1'b1;
        angle_unit_wdata <= v;
        unit_model = v;
        @(posedge clk);
        angle_unit_we <= 1'b0;
    endtask

    task automatic queue_random(int n, logic unit);
        logic [31:0] lim;
        int k;
        lim = unit ? DEG180_Q22 : PI_Q29;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                pending_angles.push_back(32'($signed($urandom_range(0, 2 * lim)) - $signed(lim)));
            else if (k < 8)
                pending_angles.push_back(lim + 32'($urandom_range(0, 3)) - 32'd2);
            else
                pending_angles.push_back($urandom);
        end
    endtask

    initial
    begin
        logic [31:0] edge_angles[$];
        edge_angles = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h0000_0001 << 29, 32'hAAAA_AAAA, 32'h5555_5555};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_unit(UNIT_RAD);
        foreach (edge_angles[i])
            pending_angles.push_back(edge_angles[i]);
        pending_angles.push_back(PI_Q29);
        pending_angles.push_back(-PI_Q29);
        pending_angles.push_back(PI_Q29 + 32'd1);
        pending_angles.push_back(-PI_Q29 - 32'd1);
        pending_angles.push_back(PI_Q29 >> 1);
        wait_drained();
        write_unit(UNIT_DEG);
        foreach (edge_angles[i])
            pending_angles.push_back(edge_angles[i]);
        pending_angles.push_back(DEG180_Q22);
        pending_angles.push_back(-DEG180_Q22);
        pending_angles.push_back(DEG180_Q22 + 32'd1);
        pending_angles.push_back(-DEG180_Q22 - 32'd1);
        pending_angles.push_back(DEG180_Q22 >> 1);
        wait_drained();
        queue_random(220, UNIT_DEG);
        wait_drained();
        write_unit(UNIT_RAD);
        queue_random(300, UNIT_RAD);
        wait_drained();
        write_unit(UNIT_DEG);
        queue_random(100, UNIT_DEG);
        wait_drained();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
